FILE: rtl/core/ctcm_pkg.sv
// Package for the corner tap code matcher.
// Holds field widths, register indexes, zone codes and reset values.
// No dependencies.
package ctcm_pkg;

    localparam int COORD_W     = 12;
    localparam int SIZE_W      = 11;
    localparam int SYM_W       = 2;
    localparam int ENTRY_W     = 12;
    localparam int MAX_CODES   = 5;
    localparam int TABLE_W     = ENTRY_W * MAX_CODES;
    localparam int ZONE_W      = 3;
    localparam int COUNT_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = TABLE_W;

    localparam int CODE_LENGTH_DEFAULT = 6;
    localparam int NUM_CODES_DEFAULT   = 5;

    localparam logic [ZONE_W-1:0] ZONE_TOP_LEFT     = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_TOP_RIGHT    = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_BOTTOM_LEFT  = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_BOTTOM_RIGHT = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_NONE         = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_CODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_TABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_VALID    = 3'd5;

    localparam logic [COORD_W-1:0]   SCREEN_WIDTH_RESET  = 12'd1024;
    localparam logic [COORD_W-1:0]   SCREEN_HEIGHT_RESET = 12'd600;
    localparam logic [SIZE_W-1:0]    CORNER_SIZE_RESET   = 11'd100;
    localparam logic [ENTRY_W-1:0]   UNLOCK_CODE_RESET   = 12'd2640;
    localparam logic [TABLE_W-1:0]   CODE_TABLE_RESET    = 60'd382829093777113168;
    localparam logic [MAX_CODES-1:0] CODE_VALID_RESET    = 5'd31;

endpackage

FILE: rtl/core/corner_tap_code_matcher_top.sv
// Top level of the corner tap code matcher.
// Depends on ctcm_pkg, ctcm_zone, ctcm_sym_cell and ctcm_match_cell.
//
// Usage:
//   Taps arrive on the input channel (in_valid/in_ready, tap_x, tap_y).
//   Each tap gives exactly one result item on the output channel
//   (out_valid/out_ready): the zone hit, the symbols held, clear, launch
//   and unlock flags, the enabled flag and the match mask.
//   The result is registered: it is in the output register the cycle after
//   the tap is taken. One tap is taken every cycle while the receiver keeps
//   taking results; the figure is set by the single output register, which
//   is reloaded in the same cycle it is read. Symbols shift through a chain
//   of CODE_LENGTH-1 cells, and the last symbol of a code is compared
//   together with the chain contents. When the receiver stalls, the result
//   holds and in_ready drops until the result is taken.
//   Reset empties the symbol chain, locks the block and loads the default
//   screen, zone size, unlock code and code table. Configuration writes
//   (cfg_we, cfg_index, cfg_data) take effect at the clock edge; unknown
//   indexes are ignored. Once unlocked, the block stays enabled until reset.
module corner_tap_code_matcher_top
    import ctcm_pkg::*;
#(
    parameter int CODE_LENGTH = CODE_LENGTH_DEFAULT,
    parameter int NUM_CODES   = NUM_CODES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_W-1:0]    tap_x,
    input  logic [COORD_W-1:0]    tap_y,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ZONE_W-1:0]     corner_hit,
    output logic [COUNT_W-1:0]    held_count,
    output logic                  code_cleared,
    output logic                  code_launched,
    output logic                  newly_unlocked,
    output logic                  is_enabled,
    output logic [MAX_CODES-1:0]  match_mask
);

    localparam int CODE_W = SYM_W * CODE_LENGTH;
    localparam int CHAIN  = (CODE_LENGTH > 1) ? CODE_LENGTH - 1 : 1;
    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(CODE_LENGTH - 1);

    // Configuration registers.
    logic [COORD_W-1:0]   screen_width_reg;
    logic [COORD_W-1:0]   screen_height_reg;
    logic [SIZE_W-1:0]    corner_size_reg;
    logic [ENTRY_W-1:0]   unlock_code_reg;
    logic [TABLE_W-1:0]   code_table_reg;
    logic [MAX_CODES-1:0] code_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
            corner_size_reg   <= CORNER_SIZE_RESET;
            unlock_code_reg   <= UNLOCK_CODE_RESET;
            code_table_reg    <= CODE_TABLE_RESET;
            code_valid_reg    <= CODE_VALID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[COORD_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[COORD_W-1:0];
                REG_CORNER_SIZE:   corner_size_reg   <= cfg_data[SIZE_W-1:0];
                REG_UNLOCK_CODE:   unlock_code_reg   <= cfg_data[ENTRY_W-1:0];
                REG_CODE_TABLE:    code_table_reg    <= cfg_data[TABLE_W-1:0];
                REG_CODE_VALID:    code_valid_reg    <= cfg_data[MAX_CODES-1:0];
                default: ;
            endcase
        end
    end

    // Handshake and zone test.
    logic              accept;
    logic [ZONE_W-1:0] zone;

    assign in_ready = !out_valid || out_ready;
    assign accept   = in_valid && in_ready;

    ctcm_zone u_zone (
        .tap_x         (tap_x),
        .tap_y         (tap_y),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .corner_size   (corner_size_reg),
        .zone          (zone)
    );

    // Tap decode and symbol chain.
    logic               is_clear;
    logic               is_symbol;
    logic               launch;
    logic [SYM_W-1:0]   new_sym;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               enabled_reg;
    logic               enabled_next;
    logic [SYM_W-1:0]   chain_q [CHAIN];
    logic [CODE_W-1:0]  code;
    logic [CODE_W-1:0]  unlock_cmp;
    logic               unlock_hit;
    logic [MAX_CODES-1:0] hits;

    assign is_clear  = accept && (zone == ZONE_BOTTOM_RIGHT);
    assign is_symbol = accept && (zone != ZONE_BOTTOM_RIGHT) && (zone != ZONE_NONE);
    assign launch    = is_symbol && (count_reg == LAST_COUNT);
    assign new_sym   = zone[SYM_W-1:0];

    // Each cell takes its upper neighbor; the top cell takes the new symbol.
    for (genvar i = 0; i < CHAIN; i++)
    begin : g_chain
        logic [SYM_W-1:0] feed;
        if (i == CHAIN - 1)
        begin : g_top
            assign feed = new_sym;
        end
        else
        begin : g_mid
            assign feed = chain_q[i+1];
        end
        ctcm_sym_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (is_symbol),
            .clear    (is_clear || launch),
            .sym_in   (feed),
            .sym_out  (chain_q[i])
        );
    end

    // Completed code: chain holds the first symbols, oldest in cell 0.
    always_comb
    begin
        code = '0;
        for (int i = 0; i < CODE_LENGTH - 1; i++)
            code[SYM_W*i +: SYM_W] = chain_q[i];
        code[SYM_W*(CODE_LENGTH-1) +: SYM_W] = new_sym;
    end

    assign unlock_cmp = unlock_code_reg[CODE_W-1:0];
    assign unlock_hit = (unlock_cmp == code);

    for (genvar k = 0; k < MAX_CODES; k++)
    begin : g_match
        if (k < NUM_CODES)
        begin : g_used
            ctcm_match_cell #(
                .CODE_W (CODE_W)
            ) u_match (
                .entry       (code_table_reg[ENTRY_W*k +: CODE_W]),
                .entry_valid (code_valid_reg[k]),
                .code        (code),
                .hit         (hits[k])
            );
        end
        else
        begin : g_unused
            assign hits[k] = 1'b0;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        enabled_next = enabled_reg;
        if (is_clear || launch)
            count_next = '0;
        else if (is_symbol)
            count_next = count_reg + COUNT_W'(1);
        if (launch && !enabled_reg && unlock_hit)
            enabled_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            enabled_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            enabled_reg <= enabled_next;
        end
    end

    // Output register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ZONE_W-1:0]    corner_hit_reg;
    logic [COUNT_W-1:0]   held_count_reg;
    logic                 cleared_reg;
    logic                 launched_reg;
    logic                 unlocked_reg;
    logic                 is_enabled_reg;
    logic [MAX_CODES-1:0] mask_reg;

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            corner_hit_reg <= zone;
            held_count_reg <= count_next;
            cleared_reg    <= is_clear;
            launched_reg   <= launch;
            unlocked_reg   <= launch && !enabled_reg && unlock_hit;
            is_enabled_reg <= enabled_next;
            mask_reg       <= (launch && enabled_reg) ? hits : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign corner_hit     = corner_hit_reg;
    assign held_count     = held_count_reg;
    assign code_cleared   = cleared_reg;
    assign code_launched  = launched_reg;
    assign newly_unlocked = unlocked_reg;
    assign is_enabled     = is_enabled_reg;
    assign match_mask     = mask_reg;

    // The enabled flag never drops once set.
    a_enabled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        enabled_reg |=> enabled_reg)
        else $error("enabled flag dropped");

    // The held count never reaches the code length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < COUNT_W'(CODE_LENGTH) || CODE_LENGTH == 0)
        else $error("symbol count out of range");

    // An unlocking launch reports no matches and leaves the block enabled.
    a_unlock_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && newly_unlocked) |->
            (is_enabled && match_mask == '0 && code_launched && held_count == '0))
        else $error("inconsistent unlock result");

    // A launch or clear always empties the buffer.
    a_empty_after: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (is_clear || launch) |=> count_reg == '0)
        else $error("buffer not emptied");

endmodule

FILE: rtl/core/ctcm_zone.sv
// Corner zone hit test for one tap against the four configured corners.
// Depends on ctcm_pkg.
module ctcm_zone
    import ctcm_pkg::*;
(
    input  logic [COORD_W-1:0] tap_x,
    input  logic [COORD_W-1:0] tap_y,
    input  logic [COORD_W-1:0] screen_width,
    input  logic [COORD_W-1:0] screen_height,
    input  logic [SIZE_W-1:0]  corner_size,
    output logic [ZONE_W-1:0]  zone
);

    // Origins of the right and bottom zones may be negative.
    logic signed [COORD_W:0] right_x;
    logic signed [COORD_W:0] bottom_y;
    logic signed [COORD_W:0] xs;
    logic signed [COORD_W:0] ys;
    logic left_in;
    logic right_in;
    logic top_in;
    logic bottom_in;

    always_comb
    begin
        right_x  = $signed({1'b0, screen_width}) - $signed({2'b00, corner_size});
        bottom_y = $signed({1'b0, screen_height}) - $signed({2'b00, corner_size});
        xs = $signed({1'b0, tap_x});
        ys = $signed({1'b0, tap_y});
        // The far edge of a right or bottom zone is the screen edge itself.
        left_in   = (tap_x != '0) && (tap_x < {1'b0, corner_size});
        top_in    = (tap_y != '0) && (tap_y < {1'b0, corner_size});
        right_in  = (xs > right_x) && (tap_x < screen_width);
        bottom_in = (ys > bottom_y) && (tap_y < screen_height);

        if (left_in && top_in)
            zone = ZONE_TOP_LEFT;
        else if (right_in && top_in)
            zone = ZONE_TOP_RIGHT;
        else if (left_in && bottom_in)
            zone = ZONE_BOTTOM_LEFT;
        else if (right_in && bottom_in)
            zone = ZONE_BOTTOM_RIGHT;
        else
            zone = ZONE_NONE;
    end

endmodule

FILE: rtl/core/ctcm_sym_cell.sv
// One cell of the entered-symbol shift chain.
// Depends on ctcm_pkg.
module ctcm_sym_cell
    import ctcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic             clear,
    input  logic [SYM_W-1:0] sym_in,
    output logic [SYM_W-1:0] sym_out
);

    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;

    always_comb
    begin
        sym_next = sym_reg;
        if (clear)
            sym_next = '0;
        else if (shift_en)
            sym_next = sym_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sym_reg <= '0;
        else
            sym_reg <= sym_next;
    end

    assign sym_out = sym_reg;

endmodule

FILE: rtl/core/ctcm_match_cell.sv
// Compare cell for one registered code entry.
// Depends on ctcm_pkg.
module ctcm_match_cell
    import ctcm_pkg::*;
#(
    parameter int CODE_W = 2 * CODE_LENGTH_DEFAULT
)
(
    input  logic [CODE_W-1:0] entry,
    input  logic              entry_valid,
    input  logic [CODE_W-1:0] code,
    output logic              hit
);

    assign hit = entry_valid && (entry == code);

endmodule

FILE: tb/tb_corner_tap_code_matcher_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for corner_tap_code_matcher_top: taps are fed from a queue,
// and every result item is checked against a predictor of the zones, symbol buffer and
// unlock logic. Depends on ctcm_pkg and the matcher RTL.
module tb_corner_tap_code_matcher_top;
    import ctcm_pkg::*;

    localparam int CODE_LEN    = CODE_LENGTH_DEFAULT;
    localparam int CODE_SLOTS  = NUM_CODES_DEFAULT;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } tap_t;

    typedef struct packed {
        logic [ZONE_W-1:0]    zone;
        logic [COUNT_W-1:0]   count;
        logic                 cleared;
        logic                 launched;
        logic                 unlocked;
        logic                 enabled;
        logic [MAX_CODES-1:0] mask;
    } tap_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [COORD_W-1:0]    tap_x     = '0;
    logic [COORD_W-1:0]    tap_y     = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ZONE_W-1:0]     corner_hit;
    logic [COUNT_W-1:0]    held_count;
    logic                  code_cleared;
    logic                  code_launched;
    logic                  newly_unlocked;
    logic                  is_enabled;
    logic [MAX_CODES-1:0]  match_mask;

    // Predictor copy of the registers and of the tap state.
    logic [COORD_W-1:0]   scr_width     = SCREEN_WIDTH_RESET;
    logic [COORD_W-1:0]   scr_height    = SCREEN_HEIGHT_RESET;
    logic [SIZE_W-1:0]    zone_side     = CORNER_SIZE_RESET;
    logic [ENTRY_W-1:0]   unlock_key    = UNLOCK_CODE_RESET;
    logic [TABLE_W-1:0]   code_tab      = CODE_TABLE_RESET;
    logic [MAX_CODES-1:0] code_en       = CODE_VALID_RESET;
    logic [SYM_W-1:0]     held_syms [6] = '{default: '0};
    int                   held_n        = 0;
    logic                 unlocked_flag = 1'b0;

    tap_t        tap_queue [$];
    tap_result_t expected_results [$];

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   hold_left     = 0;
    logic hold_start    = 1'b0;
    int   fail_count    = 0;
    int   taps_queued   = 0;
    int   taps_taken    = 0;
    int   input_stalls  = 0;
    int   n_results     = 0;
    int   n_launch      = 0;
    int   n_unlock      = 0;
    int   n_masked      = 0;
    int   n_clear       = 0;
    int   n_miss        = 0;

    corner_tap_code_matcher_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .tap_x          (tap_x),
        .tap_y          (tap_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .corner_hit     (corner_hit),
        .held_count     (held_count),
        .code_cleared   (code_cleared),
        .code_launched  (code_launched),
        .newly_unlocked (newly_unlocked),
        .is_enabled     (is_enabled),
        .match_mask     (match_mask)
    );

    always #5 clk = ~clk;

    function automatic bit in_corner(int x, int y, int x0, int y0, int s);
        return x > x0 && y > y0 && x < x0 + s && y < y0 + s;
    endfunction

    // Works out the result of one tap and advances the predicted state.
    function automatic tap_result_t score_tap(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        tap_result_t        r;
        int                 s, z, i, k, code, cmask, x0, y0;
        logic [ENTRY_W-1:0] entry;
        s = int'(zone_side);
        r = '0;
        r.zone = ZONE_NONE;
        // Origins of the right and bottom zones may go negative; the tests are signed.
        for (z = int'(ZONE_TOP_LEFT); z <= int'(ZONE_BOTTOM_RIGHT); z++)
        begin
            x0 = z[0] ? int'(scr_width) - s : 0;
            y0 = z[1] ? int'(scr_height) - s : 0;
            if (r.zone == ZONE_NONE && in_corner(int'(x), int'(y), x0, y0, s))
                r.zone = ZONE_W'(z);
        end
        if (r.zone == ZONE_BOTTOM_RIGHT)
        begin
            held_n = 0;
            r.cleared = 1'b1;
        end
        else if (r.zone != ZONE_NONE)
        begin
            if (held_n < 6)
                held_syms[held_n] = r.zone[SYM_W-1:0];
            held_n++;
            if (held_n >= CODE_LEN)
            begin
                code = 0;
                cmask = (1 << (2 * CODE_LEN)) - 1;
                for (i = 0; i < CODE_LEN && i < 6; i++)
                    code |= int'(held_syms[i]) << (2 * i);
                r.launched = 1'b1;
                if (unlocked_flag)
                begin
                    for (k = 0; k < CODE_SLOTS && k < MAX_CODES; k++)
                    begin
                        entry = code_tab[ENTRY_W*k +: ENTRY_W];
                        if (code_en[k] && (int'(entry) & cmask) == code)
                            r.mask[k] = 1'b1;
                    end
                end
                else if ((int'(unlock_key) & cmask) == code)
                begin
                    unlocked_flag = 1'b1;
                    r.unlocked = 1'b1;
                end
                held_n = 0;
            end
        end
        r.count = COUNT_W'(held_n);
        r.enabled = unlocked_flag;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Driver: offers the next queued tap when the channel is free, or idles at random.
    always @(posedge clk)
    begin : drive_taps
        tap_t next_tap;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(score_tap(tap_x, tap_y));
                taps_taken++;
            end
            if (in_valid && !in_ready)
                input_stalls++;
            if (!in_valid || in_ready)
            begin
                if (tap_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_tap = tap_queue.pop_front();
                    in_valid <= 1'b1;
                    tap_x <= next_tap.x;
                    tap_y <= next_tap.y;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only has to look at it.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compares each accepted result item with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        tap_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item arrived with no tap outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("corner_hit", want.zone, corner_hit);
                    check_field("held_count", want.count, held_count);
                    check_field("code_cleared", want.cleared, code_cleared);
                    check_field("code_launched", want.launched, code_launched);
                    check_field("newly_unlocked", want.unlocked, newly_unlocked);
                    check_field("is_enabled", want.enabled, is_enabled);
                    check_field("match_mask", want.mask, match_mask);
                    n_results++;
                    n_launch += want.launched;
                    n_unlock += want.unlocked;
                    n_clear  += want.cleared;
                    n_masked += (want.mask != '0);
                    n_miss   += (want.zone == ZONE_NONE);
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= stall_pct);
        end
    end

    task automatic push_tap(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        tap_queue.push_back('{x: x, y: y});
        taps_queued++;
    endtask

    // Queues a tap inside zone z under the current geometry, or on one of its edges.
    task automatic push_aim(input int z, input bit graze);
        int s, x0, y0, lo_x, hi_x, lo_y, hi_y, px, py;
        s    = int'(zone_side);
        x0   = z[0] ? int'(scr_width) - s : 0;
        y0   = z[1] ? int'(scr_height) - s : 0;
        lo_x = (x0 + 1 > 0) ? x0 + 1 : 0;
        hi_x = (x0 + s - 1 < COORD_MAX) ? x0 + s - 1 : COORD_MAX;
        lo_y = (y0 + 1 > 0) ? y0 + 1 : 0;
        hi_y = (y0 + s - 1 < COORD_MAX) ? y0 + s - 1 : COORD_MAX;
        if (lo_x > hi_x || lo_y > hi_y)
        begin
            px = $urandom_range(COORD_MAX, 0);
            py = $urandom_range(COORD_MAX, 0);
        end
        else
        begin
            px = $urandom_range(hi_x, lo_x);
            py = $urandom_range(hi_y, lo_y);
        end
        if (graze)
        begin
            case ($urandom_range(3, 0))
                0:       px = x0;
                1:       px = x0 + s;
                2:       py = y0;
                default: py = y0 + s;
            endcase
            px = (px < 0) ? 0 : ((px > COORD_MAX) ? COORD_MAX : px);
            py = (py < 0) ? 0 : ((py > COORD_MAX) ? COORD_MAX : py);
        end
        push_tap(COORD_W'(px), COORD_W'(py));
    endtask

    // Taps out a whole code; symbol 3 cannot be entered, so it becomes a random symbol.
    task automatic queue_code(input logic [ENTRY_W-1:0] code, input bit lead_clear);
        int i, sym;
        if (lead_clear)
            push_aim(int'(ZONE_BOTTOM_RIGHT), 1'b0);
        for (i = 0; i < CODE_LEN; i++)
        begin
            sym = int'(code[2*i +: 2]);
            if (sym == int'(ZONE_BOTTOM_RIGHT))
                sym = $urandom_range(2, 0);
            push_aim(sym, 1'b0);
        end
    endtask

    function automatic logic [ENTRY_W-1:0] rand_code();
        logic [ENTRY_W-1:0] c;
        int                 i;
        for (i = 0; i < ENTRY_W / 2; i++)
            c[2*i +: 2] = ($urandom_range(9, 0) == 0) ? 2'd3 : SYM_W'($urandom_range(2, 0));
        return c;
    endfunction

    // Entries come from a small pool so that duplicates are common.
    function automatic logic [TABLE_W-1:0] rand_table();
        logic [ENTRY_W-1:0] pool [3];
        logic [TABLE_W-1:0] t;
        int                 k;
        for (k = 0; k < 3; k++)
            pool[k] = rand_code();
        for (k = 0; k < MAX_CODES; k++)
            t[ENTRY_W*k +: ENTRY_W] = pool[$urandom_range(2, 0)];
        return t;
    endfunction

    // Bits above the register width carry junk, which the block must drop.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                             input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'({$urandom(), $urandom()});
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (junk << width) | value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                              input logic [SIZE_W-1:0] s, input logic [ENTRY_W-1:0] key,
                              input logic [TABLE_W-1:0] tab, input logic [MAX_CODES-1:0] en);
        write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(w), COORD_W);
        write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(h), COORD_W);
        write_reg(REG_CORNER_SIZE, CFG_DATA_W'(s), SIZE_W);
        write_reg(REG_UNLOCK_CODE, CFG_DATA_W'(key), ENTRY_W);
        write_reg(REG_CODE_TABLE, CFG_DATA_W'(tab), TABLE_W);
        write_reg(REG_CODE_VALID, CFG_DATA_W'(en), MAX_CODES);
        // Writes to unused indexes must leave everything alone.
        write_reg($urandom_range(1, 0) ? REG_SPARE_LO : REG_SPARE_HI, '0, 0);
        scr_width  = w;
        scr_height = h;
        zone_side  = s;
        unlock_key = key;
        code_tab   = tab;
        code_en    = en;
    endtask

    task automatic set_config_random();
        set_config(COORD_W'($urandom_range(COORD_MAX, 1)), COORD_W'($urandom_range(COORD_MAX, 1)),
                   SIZE_W'($urandom_range(1, 0) ? $urandom_range(200, 1)
                                                : $urandom_range(2047, 1)),
                   rand_code(), rand_table(), MAX_CODES'($urandom()));
    endtask

    task automatic set_idle(input int snd, input int rcv);
        send_idle_pct = snd;
        stall_pct     = rcv;
    endtask

    // Mostly whole codes (often after a clear), the rest partial codes, clears,
    // edge taps and taps anywhere.
    task automatic run_random(input int n);
        int                 goal, pick, slot;
        logic [ENTRY_W-1:0] code;
        goal = taps_queued + n;
        while (taps_queued < goal)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 45)
            begin
                slot = $urandom_range(9, 0);
                if (slot < 4)
                    code = code_tab[ENTRY_W*$urandom_range(MAX_CODES-1, 0) +: ENTRY_W];
                else if (slot == 4)
                    code = unlock_key;
                else
                    code = rand_code();
                queue_code(code, $urandom_range(9, 0) < 7);
            end
            else if (pick < 60)
                push_aim($urandom_range(2, 0), 1'b0);
            else if (pick < 68)
                push_aim(int'(ZONE_BOTTOM_RIGHT), 1'b0);
            else if (pick < 80)
                push_aim($urandom_range(3, 0), 1'b1);
            else
                push_tap(COORD_W'($urandom()), COORD_W'($urandom()));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tap_queue.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: 1024 x 600 with zones of 100; still locked.
        push_tap(12'd0, 12'd0);
        push_tap(12'd4095, 12'd4095);
        push_tap(12'd1, 12'd1);
        push_tap(12'd99, 12'd99);
        push_tap(12'd100, 12'd50);
        push_tap(12'd1023, 12'd1);
        push_tap(12'd1, 12'd599);
        push_tap(12'd1023, 12'd599);
        repeat (6) push_tap(12'd50, 12'd50);
        wait_drained();

        // Locked random phase: the unlock code holds symbol 3, so it can never match.
        set_config(12'd1024, 12'd600, 11'd100, 12'hFFF, '0, 5'h1F);
        run_random(150);
        wait_drained();

        // Unlock with the all-zero code, then a code held in three valid slots
        // and one invalid slot.
        set_config(12'd1024, 12'd600, 11'd100, 12'h000,
                   {12'h555, 12'h249, 12'h249, 12'h249, 12'h249}, 5'b11011);
        push_tap(12'd1023, 12'd599);
        repeat (6) push_tap(12'd50, 12'd50);
        queue_code(12'h249, 1'b0);
        wait_drained();

        set_idle(0, 0);
        set_config(12'd1024, 12'd600, 11'd100, rand_code(), rand_table(), 5'h1F);
        run_random(200);
        wait_drained();

        // Zones far larger than the screen: negative origins.
        set_idle(72, 0);
        set_config(12'd1, 12'd1, 11'd2047, 12'h000, rand_table(), MAX_CODES'($urandom()));
        run_random(200);
        wait_drained();

        // Zone of one unit: the strict tests admit no tap at all.
        set_idle(0, 72);
        set_config(12'd4095, 12'd4095, 11'd1, 12'hFFF, '0, 5'h1F);
        run_random(80);
        wait_drained();

        set_idle(9, 9);
        set_config_random();
        run_random(250);
        wait_drained();

        // Widest settings; the receiver holds off long enough to back up the input.
        set_idle(0, 0);
        set_config(12'd4095, 12'd4095, 11'd2047, 12'hAAA, {TABLE_W{1'b1}}, 5'h00);
        run_random(200);
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        wait_drained();

        set_idle(72, 0);
        set_config_random();
        run_random(200);
        wait_drained();

        set_idle(0, 72);
        set_config_random();
        run_random(200);
        wait_drained();

        set_idle(9, 9);
        set_config_random();
        run_random(150);
        wait_drained();

        repeat (10) @(posedge clk);
        $display("Checked %0d result items for %0d taps across eleven register settings.",
                 n_results, taps_taken);
        $display("Covered %0d launches, %0d unlocks, %0d matches, %0d clears, %0d misses,",
                 n_launch, n_unlock, n_masked, n_clear, n_miss);
        $display("and %0d input stall cycles.", input_stalls);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $error("run did not complete in time");
        $display("TEST FAILED");
        $finish;
    end

endmodule
